// ----- rtl/mhpq_pkg.sv -----
// Package for the max-heap priority queue: sizes, status codes and the
// per-cell command struct shared by the controller and the cell row.
// No dependencies.
package mhpq_pkg;

    // Number of heap slots; one slot is reserved, so SLOTS-1 entries fit
    localparam int SLOTS   = 64;
    localparam int CELLS   = SLOTS - 1;
    localparam int CNT_W   = $clog2(SLOTS);
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 6;

    // Input item kind, carried on tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Result status, carried on tuser
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command broadcast to every cell for one transfer
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

// ----- rtl/max_heap_priority_queue.sv -----
// Top level of the max priority queue: controller plus a row of sort cells.
// Depends on mhpq_pkg, mhpq_cell and mhpq_ctrl.
//
// Usage:
//   Slave channel carries one operation per transfer: tuser is the mode
//   (0 insert, 1 delete maximum), tdata the signed 32-bit value to insert.
//   Master channel returns exactly one result per operation: tuser is the
//   status (0 done, 1 full, 2 empty), tdata holds the removed maximum in
//   bits 31:0 (zero unless a delete succeeded) and the entry count after
//   the operation in bits 37:32.
//   The queue holds up to SLOTS-1 entries, kept sorted in a row of cells
//   that all shift or hold in the same cycle: the result is valid the
//   cycle after the input transfer and one operation is taken every cycle
//   while the result side keeps up.
//   A single result register separates the channels; when the receiver
//   stalls with a result pending, the input is held off until it drains.
//   Synchronous active-low reset empties the queue and drops any pending
//   result; stored values are not cleared.
module max_heap_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // value[31:0]
    input  logic        i_s_tuser,  // mode[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // removed_value[31:0], item_count[37:32], zero[39:38]
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    mhpq_pkg::t_cell_cmd               cmd;
    logic [mhpq_pkg::CNT_W-1:0]        count;
    mhpq_pkg::t_status                 status;
    logic signed [mhpq_pkg::VAL_W-1:0] removed;
    logic [mhpq_pkg::COUNT_W-1:0]      item_count;
    logic signed [mhpq_pkg::VAL_W-1:0] cell_val [mhpq_pkg::CELLS];
    logic                              cell_ge  [mhpq_pkg::CELLS];

    // Controller and result stage
    mhpq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_mode       (i_s_tuser),
        .i_value      (i_s_tdata),
        .i_root       (cell_val[0]),
        .o_cmd        (cmd),
        .o_count      (count),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_status     (status),
        .o_removed    (removed),
        .o_item_count (item_count)
    );

    // Row of sort cells, largest entry at the head
    for (genvar gi = 0; gi < mhpq_pkg::CELLS; gi++) begin : g_cell
        logic                              prev_ge;
        logic signed [mhpq_pkg::VAL_W-1:0] prev_val;
        logic signed [mhpq_pkg::VAL_W-1:0] next_val;

        if (gi == 0) begin : g_head
            assign prev_ge  = 1'b0;
            assign prev_val = '0;
        end else begin : g_body
            assign prev_ge  = cell_ge[gi-1];
            assign prev_val = cell_val[gi-1];
        end

        if (gi == mhpq_pkg::CELLS - 1) begin : g_tail
            assign next_val = '0;
        end else begin : g_link
            assign next_val = cell_val[gi+1];
        end

        mhpq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_first    (gi == 0),
            .i_occupied (mhpq_pkg::CNT_W'(gi) < count),
            .i_prev_ge  (prev_ge),
            .i_prev_val (prev_val),
            .i_next_val (next_val),
            .o_ge       (cell_ge[gi]),
            .o_val      (cell_val[gi])
        );
    end

    // Result packing
    assign o_m_tdata = {2'b00, item_count, removed};
    assign o_m_tuser = status;

endmodule

// ----- rtl/mhpq_cell.sv -----
// One cell of the sorted row: holds a single entry and trades it with its
// neighbours on insert (shift towards the tail) or delete (shift to the head).
// Depends on mhpq_pkg.
module mhpq_cell (
    input  logic                            i_clk,
    input  mhpq_pkg::t_cell_cmd             i_cmd,
    input  logic                            i_first,    // cell at the head
    input  logic                            i_occupied, // holds a live entry
    input  logic                            i_prev_ge,  // head-side cell keeps its entry
    input  logic signed [mhpq_pkg::VAL_W-1:0] i_prev_val,
    input  logic signed [mhpq_pkg::VAL_W-1:0] i_next_val,
    output logic                            o_ge,
    output logic signed [mhpq_pkg::VAL_W-1:0] o_val
);

    logic signed [mhpq_pkg::VAL_W-1:0] r_val;
    logic signed [mhpq_pkg::VAL_W-1:0] n_val;

    // Entry stays ahead of the new value when it is at least as large
    assign o_ge  = i_occupied && (r_val >= i_cmd.value);
    assign o_val = r_val;

    // Keep, take the new value, or take the neighbour's entry
    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (!o_ge) begin
                if (i_first || i_prev_ge) begin
                    n_val = i_cmd.value;
                end else begin
                    n_val = i_prev_val;
                end
            end
        end else if (i_cmd.del) begin
            n_val = i_next_val;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- rtl/mhpq_ctrl.sv -----
// Controller: input handshake, entry count, full/empty decisions and the
// registered result stage. Depends on mhpq_pkg.
module mhpq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic                              i_mode,
    input  logic signed [mhpq_pkg::VAL_W-1:0] i_value,
    input  logic signed [mhpq_pkg::VAL_W-1:0] i_root,
    output mhpq_pkg::t_cell_cmd               o_cmd,
    output logic [mhpq_pkg::CNT_W-1:0]        o_count,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output mhpq_pkg::t_status                 o_status,
    output logic signed [mhpq_pkg::VAL_W-1:0] o_removed,
    output logic [mhpq_pkg::COUNT_W-1:0]      o_item_count
);

    logic [mhpq_pkg::CNT_W-1:0]        r_count;
    logic [mhpq_pkg::CNT_W-1:0]        n_count;
    logic                              r_out_valid;
    mhpq_pkg::t_status                 r_status;
    mhpq_pkg::t_status                 n_status;
    logic signed [mhpq_pkg::VAL_W-1:0] r_removed;
    logic signed [mhpq_pkg::VAL_W-1:0] n_removed;
    logic                              accept;
    logic                              full;
    logic                              empty;

    // Result register frees up when empty or drained this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign full  = (r_count >= mhpq_pkg::CNT_W'(mhpq_pkg::CELLS));
    assign empty = (r_count == '0);

    // Command for the cell row
    always_comb begin
        o_cmd.ins   = accept && (i_mode == mhpq_pkg::MODE_INSERT) && !full;
        o_cmd.del   = accept && (i_mode == mhpq_pkg::MODE_DELETE) && !empty;
        o_cmd.value = i_value;
    end

    // Result and next count
    always_comb begin
        n_count   = r_count;
        n_status  = mhpq_pkg::ST_DONE;
        n_removed = '0;
        if (i_mode == mhpq_pkg::MODE_INSERT) begin
            if (full) begin
                n_status = mhpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = mhpq_pkg::ST_EMPTY;
            end else begin
                n_count   = r_count - 1'b1;
                n_removed = i_root;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_count      = r_count;
    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_status;
    assign o_removed    = r_removed;
    assign o_item_count = mhpq_pkg::COUNT_W'(r_count);

endmodule

// ----- rtl/mhpq_checker.sv -----
// Port-level checker for the max priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue.
module mhpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Every input transfer yields a result on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("no result after input transfer");

    // Input side is open whenever no result is pending
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with no result pending");

    // A failed operation returns no value
    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != mhpq_pkg::ST_DONE) |-> (o_m_tdata[31:0] == '0))
        else $error("value returned on a failed operation");

    // Empty report comes with a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == mhpq_pkg::ST_EMPTY) |-> (o_m_tdata[37:32] == '0))
        else $error("empty status with entries held");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- dv/max_heap_priority_queue_check.sv -----
// Scoreboard for the max-heap priority queue: keeps its own heap, works out
// the result of every operation transfer and compares the result transfers.
// Depends on mhpq_pkg.
module max_heap_priority_queue_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // value[31:0]
    input  logic        i_s_tuser,  // mode[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,  // removed_value[31:0], item_count[37:32], zero[39:38]
    input  logic [1:0]  i_m_tuser,  // status[1:0]
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        mhpq_pkg::t_status                 status;
        logic signed [mhpq_pkg::VAL_W-1:0] removed;
        logic [mhpq_pkg::COUNT_W-1:0]      count;
    } t_heap_result;

    // Shadow heap, 1-based, and its entry count
    logic signed [mhpq_pkg::VAL_W-1:0] heap_vals [mhpq_pkg::SLOTS];
    int                                held = 0;
    t_heap_result                      due_results [$];
    int                                errors = 0;

    // One operation on the shadow heap
    function automatic t_heap_result heap_step(
        input logic                              mode,
        input logic signed [mhpq_pkg::VAL_W-1:0] value
    );
        t_heap_result                      res;
        int                                pos;
        int                                best;
        logic signed [mhpq_pkg::VAL_W-1:0] tmp;
        res.status  = mhpq_pkg::ST_DONE;
        res.removed = '0;
        if (mode == mhpq_pkg::MODE_INSERT) begin
            if (held >= mhpq_pkg::SLOTS - 1) begin
                res.status = mhpq_pkg::ST_FULL;
            end else begin
                held++;
                heap_vals[held] = value;
                pos = held;
                // sift up past strictly smaller parents only
                while (pos > 1 && heap_vals[pos] > heap_vals[pos / 2]) begin
                    tmp                = heap_vals[pos];
                    heap_vals[pos]     = heap_vals[pos / 2];
                    heap_vals[pos / 2] = tmp;
                    pos                = pos / 2;
                end
            end
        end else if (held == 0) begin
            res.status = mhpq_pkg::ST_EMPTY;
        end else begin
            res.removed  = heap_vals[1];
            heap_vals[1] = heap_vals[held];
            held--;
            pos = 1;
            // sift down; a tie between children goes left
            forever begin
                best = pos;
                if (2 * pos <= held && heap_vals[2 * pos] > heap_vals[best])
                    best = 2 * pos;
                if (2 * pos + 1 <= held && heap_vals[2 * pos + 1] > heap_vals[best])
                    best = 2 * pos + 1;
                if (best == pos)
                    break;
                tmp             = heap_vals[pos];
                heap_vals[pos]  = heap_vals[best];
                heap_vals[best] = tmp;
                pos             = best;
            end
        end
        res.count = mhpq_pkg::COUNT_W'(held);
        return res;
    endfunction

    // Watch both channels; results are checked before the new operation is queued
    always @(posedge i_clk) begin : watch
        t_heap_result want;
        if (!i_rst_n) begin
            held = 0;
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual tuser %0d tdata %h",
                             $time, i_m_tuser, i_m_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (i_m_tuser !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_m_tuser);
                    end
                    if (i_m_tdata[31:0] !== want.removed) begin
                        errors++;
                        $display("%0t: removed value expected %0d actual %0d",
                                 $time, want.removed, $signed(i_m_tdata[31:0]));
                    end
                    if (i_m_tdata[37:32] !== want.count) begin
                        errors++;
                        $display("%0t: item count expected %0d actual %0d",
                                 $time, want.count, i_m_tdata[37:32]);
                    end
                    if (i_m_tdata[39:38] !== 2'b00) begin
                        errors++;
                        $display("%0t: pad bits expected 0 actual %b",
                                 $time, i_m_tdata[39:38]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                due_results.push_back(heap_step(i_s_tuser, i_s_tdata));
        end
        o_errors  <= errors;
        o_pending <= due_results.size();
    end

endmodule

// ----- dv/max_heap_priority_queue_test.sv -----
// Testbench top for the max-heap priority queue: clock, reset, operation
// stimulus and result back-pressure, and the final verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and max_heap_priority_queue_check.
module max_heap_priority_queue_test;

    localparam int RANDOM_OPS  = 1150;
    localparam int IDLE_PCT    = 36;
    localparam int CYCLE_LIMIT = 200000;

    // Extremes, sign boundary, ties and alternating bit patterns
    localparam logic [31:0] EDGE_VALS [10] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'hAAAA_AAAA, 32'h5555_5555
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = mhpq_pkg::MODE_INSERT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        steady   = 1'b0;
    int          errors;
    int          pending;
    int          cycles   = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    max_heap_priority_queue u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    max_heap_priority_queue_check u_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Result side stalls at random, never during the steady stretch
    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL max_heap_priority_queue");
            $finish;
        end
    end

    // Mostly random values, with extremes and a narrow band for ties
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // One operation transfer, with random gaps ahead of it
    task automatic send_op(input logic mode, input logic [31:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= $urandom_range(0, 1);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        int bias;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: delete on empty, edge values and ties, drain past empty
        send_op(mhpq_pkg::MODE_DELETE, 32'hFFFF_FFFF);
        foreach (EDGE_VALS[i])
            send_op(mhpq_pkg::MODE_INSERT, EDGE_VALS[i]);
        repeat (11)
            send_op(mhpq_pkg::MODE_DELETE, $urandom);

        // Random bursts; insert-heavy ones fill the heap, delete-heavy ones drain it
        while (sent < RANDOM_OPS) begin
            burst = $urandom_range(20, 120);
            case ($urandom_range(0, 4))
                0:       bias = 95;
                1:       bias = 75;
                2:       bias = 50;
                3:       bias = 25;
                default: bias = 5;
            endcase
            for (int k = 0; k < burst && sent < RANDOM_OPS; k++) begin
                if (sent == 350)
                    steady <= 1'b1;
                else if (sent == 600)
                    steady <= 1'b0;
                send_op(($urandom_range(0, 99) < bias) ? mhpq_pkg::MODE_INSERT
                                                       : mhpq_pkg::MODE_DELETE,
                        pick_value());
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then keep waiting for stray results before the verdict
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS max_heap_priority_queue");
        else
            $display("FAIL max_heap_priority_queue");
        $finish;
    end

endmodule
